@@ hw/rtl/cch_pkg.sv @@
// Shared types, widths, constants and the arctangent table for the compass heading hold block.
`timescale 1ns / 1ps

package cch_pkg;

  // Field widths
  localparam int MAG_W   = 16;
  localparam int ANG_W   = 18;
  localparam int TURN_W  = 16;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  // Datapath widths
  localparam int XY_W    = 27;
  localparam int Z_W     = 36;
  localparam int ZL_W    = 18;
  localparam int MA_W    = 20;
  localparam int MB_W    = 28;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 60;
  localparam int TQ_W    = 20;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_LEN   = 24;

  // Default parameter values
  localparam int CAL_SAMPLES_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_DEGREES = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] SMOOTHING_WEIGHT_RST = 9'd64;
  localparam logic [CFG_W-1:0] TURN_GAIN_RST        = 9'd64;
  localparam logic [CFG_W-1:0] DEADBAND_DEGREES_RST = 9'd3;

  // Q8 helpers
  localparam int Q8_FRAC = 8;
  localparam int Q8_HALF = 128;
  localparam int Q8_MASK = 255;
  localparam logic [CFG_W-1:0] Q8_ONE = 9'd256;

  // Angle constants: pi/2 in Q32 radians, and round(2^16 * 180 / 3.14).
  localparam logic signed [Z_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam int DEG_SCALE_Q16 = 3756841;
  localparam int DEG_FRAC = 40;
  localparam logic signed [ACC_W-1:0] DEG_ROUND = 60'sd549755813888;

  // Largest whole-degree heading magnitude after truncation.
  localparam int MAX_WHOLE_DEG = 181;

  localparam int TURN_MAX = 32767;
  localparam int TURN_MIN = -32768;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctl_t;

  // atan(2^-i) in Q32 radians.
  function automatic logic [Z_W-1:0] atan_q32(input logic [ATAN_IDX_W-1:0] i);
    logic [Z_W-1:0] r;
    case (i)
      5'd0:  r = 36'd3373259426;
      5'd1:  r = 36'd1991351318;
      5'd2:  r = 36'd1052175346;
      5'd3:  r = 36'd534100635;
      5'd4:  r = 36'd268086748;
      5'd5:  r = 36'd134174063;
      5'd6:  r = 36'd67103403;
      5'd7:  r = 36'd33553749;
      5'd8:  r = 36'd16777131;
      5'd9:  r = 36'd8388597;
      5'd10: r = 36'd4194303;
      5'd11: r = 36'd2097152;
      5'd12: r = 36'd1048576;
      5'd13: r = 36'd524288;
      5'd14: r = 36'd262144;
      5'd15: r = 36'd131072;
      5'd16: r = 36'd65536;
      5'd17: r = 36'd32768;
      5'd18: r = 36'd16384;
      5'd19: r = 36'd8192;
      5'd20: r = 36'd4096;
      5'd21: r = 36'd2048;
      5'd22: r = 36'd1024;
      5'd23: r = 36'd512;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/cch_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module cch_mul (
  input  logic                               clk,
  input  logic signed [cch_pkg::MA_W-1:0]    a,
  input  logic signed [cch_pkg::MB_W-1:0]    b,
  output logic signed [cch_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ hw/rtl/cch_cordic.sv @@
// Iterative vectoring CORDIC: one micro-rotation per cycle while step is high, with a barrel shift.
`timescale 1ns / 1ps

module cch_cordic #(
  parameter int STEP_W = $clog2(cch_pkg::CORDIC_STEPS_DEF)
) (
  input  logic                             clk,
  input  cch_pkg::cordic_ctl_t             ctl,
  input  logic signed [cch_pkg::MAG_W-1:0] y_in,
  input  logic signed [cch_pkg::MAG_W-1:0] x_in,
  input  logic [STEP_W-1:0]                idx,
  output logic signed [cch_pkg::Z_W-1:0]   z
);

  logic signed [cch_pkg::XY_W-1:0] x, y, x0, y0, x_ld, y_ld, x_next, y_next, dx, dy;
  logic signed [cch_pkg::Z_W-1:0]  z_ld, z_next, ang;
  logic [cch_pkg::ATAN_IDX_W-1:0]  sh;

  // Scale by 256, then pre-rotate by 90 degrees into the right half plane.
  always_comb begin
    x0 = cch_pkg::XY_W'(x_in) <<< cch_pkg::Q8_FRAC;
    y0 = cch_pkg::XY_W'(y_in) <<< cch_pkg::Q8_FRAC;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x_ld = y0;
        y_ld = -x0;
        z_ld = cch_pkg::HALF_PI_Q32;
      end else begin
        x_ld = -y0;
        y_ld = x0;
        z_ld = -cch_pkg::HALF_PI_Q32;
      end
    end else begin
      x_ld = x0;
      y_ld = y0;
      z_ld = '0;
    end
  end

  always_comb begin
    sh  = cch_pkg::ATAN_IDX_W'(idx);
    dx  = y >>> sh;
    dy  = x >>> sh;
    ang = $signed(cch_pkg::atan_q32(sh));
    if (y > 0) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + ang;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= x_ld;
      y <= y_ld;
      z <= z_ld;
    end else if (ctl.step) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

@@ hw/rtl/compass_heading_hold.sv @@
// Top level: sequencer, calibration, smoothing filter and turn command around a shared multiplier.
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// sample    sample_valid / sample_stall mag_y_reading, mag_z_reading, hold_zero
// result    result_valid / result_stall filtered_heading, turn_command, calibrated
// config    cfg_write                   cfg_index, cfg_data
//
// A tracking sample runs the CORDIC rotations, degree conversion, filter and turn command
// before the next is accepted, paced by the one-rotation-per-cycle CORDIC and shared multiplier.
// A calibration sample updates the running sum instead; the last also divides by the count.
// Reset is synchronous and returns the registers and calibration to their initial values.
// sample_stall is high while a sample is in work; a finished result waits in the output
// register, and the sequencer holds its last state only while that register is still full.

module compass_heading_hold #(
  parameter int CAL_SAMPLES  = cch_pkg::CAL_SAMPLES_DEF,
  parameter int CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [cch_pkg::MAG_W-1:0]     mag_y_reading,
  input  logic signed [cch_pkg::MAG_W-1:0]     mag_z_reading,
  input  logic                                 hold_zero,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [cch_pkg::ANG_W-1:0]     filtered_heading,
  output logic signed [cch_pkg::TURN_W-1:0]    turn_command,
  output logic                                 calibrated,
  input  logic                                 cfg_write,
  input  logic [cch_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cch_pkg::CFG_W-1:0]            cfg_data
);

  localparam int OFS_W  = $clog2(cch_pkg::MAX_WHOLE_DEG * CAL_SAMPLES + 1) + 1;
  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int T_W    = OFS_W + cch_pkg::ANG_W;
  localparam int DIV_K  = OFS_W + 9;
  localparam longint RECIP =
    ((longint'(1) << DIV_K) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROT  = 4'd1;
  localparam logic [3:0] S_MLO  = 4'd2;
  localparam logic [3:0] S_MHI  = 4'd3;
  localparam logic [3:0] S_HEAD = 4'd4;
  localparam logic [3:0] S_CAL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DIVQ = 4'd7;
  localparam logic [3:0] S_FA   = 4'd8;
  localparam logic [3:0] S_FB   = 4'd9;
  localparam logic [3:0] S_FC   = 4'd10;
  localparam logic [3:0] S_TA   = 4'd11;
  localparam logic [3:0] S_TB   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]        state;
  logic [STEP_W-1:0] step_idx;
  logic              accept;

  logic [cch_pkg::CFG_W-1:0] w_reg, g_reg, db_reg;
  logic [cch_pkg::CFG_W-1:0] w_eff, w_comp, g_eff;

  logic [CNT_W-1:0]                  cal_count;
  logic                              cal_done;
  logic signed [OFS_W-1:0]           offset_sum;
  logic signed [cch_pkg::ANG_W-1:0]  smoothed;

  logic                              hold_r, zero_r, div_neg;
  logic signed [cch_pkg::ANG_W-1:0]  h_reg;
  logic signed [cch_pkg::TURN_W-1:0] turn_r;
  logic signed [cch_pkg::ACC_W-1:0]  acc;

  logic signed [cch_pkg::MAG_W-1:0]  neg_y, neg_z;
  cch_pkg::cordic_ctl_t              cordic_ctl;
  logic signed [cch_pkg::Z_W-1:0]    cz;

  logic signed [cch_pkg::MA_W-1:0]   mul_a;
  logic signed [cch_pkg::MB_W-1:0]   mul_b;
  logic signed [cch_pkg::PROD_W-1:0] prod;

  logic signed [cch_pkg::ACC_W-1:0]  head_sum, filt_sum, turn_sum;
  logic signed [cch_pkg::ANG_W-1:0]  head_calc, filt_new;
  logic signed [T_W-1:0]             cal_t, cal_adj;
  logic signed [OFS_W-1:0]           cal_new, div_q;
  logic signed [OFS_W:0]             ofs_ext, ofs_neg;
  logic [OFS_W:0]                    div_num;
  logic signed [T_W-1:0]             diff;
  logic signed [cch_pkg::TQ_W-1:0]   turn_q;
  logic signed [cch_pkg::TURN_W-1:0] turn_sat, turn_val;
  logic [cch_pkg::ANG_W:0]           mag;
  logic [cch_pkg::ANG_W-8:0]         whole_deg;
  logic                              in_deadband;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;

  // Both axes are negated with 16-bit wrap before the heading is formed.
  assign neg_y = -mag_y_reading;
  assign neg_z = -mag_z_reading;

  assign cordic_ctl.load = accept;
  assign cordic_ctl.step = (state == S_ROT);

  cch_cordic #(
    .STEP_W (STEP_W)
  ) u_cordic (
    .clk  (clk),
    .ctl  (cordic_ctl),
    .y_in (neg_y),
    .x_in (neg_z),
    .idx  (step_idx),
    .z    (cz)
  );

  cch_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Register values above 256 act as 256.
  always_comb begin
    w_eff  = w_reg[cch_pkg::CFG_W-1] ? cch_pkg::Q8_ONE : w_reg;
    g_eff  = g_reg[cch_pkg::CFG_W-1] ? cch_pkg::Q8_ONE : g_reg;
    w_comp = cch_pkg::Q8_ONE - w_eff;
  end

  always_comb begin
    // Degree conversion: z * scale, split into an unsigned low part and a signed high part.
    head_sum  = acc + (cch_pkg::ACC_W'(prod) <<< cch_pkg::ZL_W);
    head_calc = head_sum[cch_pkg::DEG_FRAC +: cch_pkg::ANG_W];

    // Running sum of whole degrees, truncated toward zero.
    cal_t   = (T_W'(offset_sum) <<< cch_pkg::Q8_FRAC) + T_W'(h_reg);
    cal_adj = cal_t + ((cal_t < 0) ? T_W'(cch_pkg::Q8_MASK) : '0);
    cal_new = cal_adj[cch_pkg::Q8_FRAC +: OFS_W];

    // Floor division by the sample count through a reciprocal multiply on the magnitude.
    ofs_ext = (OFS_W + 1)'(offset_sum);
    ofs_neg = -ofs_ext;
    div_num = (offset_sum < 0) ? ($unsigned(ofs_neg) + (OFS_W + 1)'(CAL_SAMPLES - 1))
                               : $unsigned(ofs_ext);
    div_q   = $signed(prod[DIV_K +: OFS_W]);

    diff     = T_W'(h_reg) - (T_W'(offset_sum) <<< cch_pkg::Q8_FRAC);
    filt_sum = acc + cch_pkg::ACC_W'(prod);
    filt_new = filt_sum[cch_pkg::Q8_FRAC +: cch_pkg::ANG_W];

    turn_sum = cch_pkg::ACC_W'(prod) + cch_pkg::ACC_W'(cch_pkg::Q8_HALF);
    turn_q   = turn_sum[cch_pkg::Q8_FRAC +: cch_pkg::TQ_W];
    if (turn_q > cch_pkg::TQ_W'(cch_pkg::TURN_MAX)) begin
      turn_sat = cch_pkg::TURN_W'(cch_pkg::TURN_MAX);
    end else if (turn_q < cch_pkg::TQ_W'(cch_pkg::TURN_MIN)) begin
      turn_sat = cch_pkg::TURN_W'(cch_pkg::TURN_MIN);
    end else begin
      turn_sat = turn_q[cch_pkg::TURN_W-1:0];
    end

    mag         = (smoothed < 0) ? $unsigned(-(cch_pkg::ANG_W + 1)'(smoothed))
                                 : $unsigned((cch_pkg::ANG_W + 1)'(smoothed));
    whole_deg   = mag[cch_pkg::ANG_W:cch_pkg::Q8_FRAC];
    in_deadband = whole_deg < (cch_pkg::ANG_W - 7)'(db_reg);
    turn_val    = (hold_r || in_deadband) ? '0 : turn_sat;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MLO: begin
        mul_a = $signed(cch_pkg::MA_W'(cz[cch_pkg::ZL_W-1:0]));
        mul_b = cch_pkg::MB_W'(cch_pkg::DEG_SCALE_Q16);
      end
      S_MHI: begin
        mul_a = cch_pkg::MA_W'(cz >>> cch_pkg::ZL_W);
        mul_b = cch_pkg::MB_W'(cch_pkg::DEG_SCALE_Q16);
      end
      S_DIV: begin
        mul_a = $signed(cch_pkg::MA_W'(div_num));
        mul_b = cch_pkg::MB_W'(RECIP);
      end
      S_FA: begin
        mul_a = cch_pkg::MA_W'(smoothed);
        mul_b = $signed(cch_pkg::MB_W'(w_comp));
      end
      S_FB: begin
        mul_a = cch_pkg::MA_W'(diff);
        mul_b = $signed(cch_pkg::MB_W'(w_eff));
      end
      S_TA: begin
        mul_a = cch_pkg::MA_W'(smoothed);
        mul_b = $signed(cch_pkg::MB_W'(g_eff));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control, configuration and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_idx     <= '0;
      result_valid <= 1'b0;
      cal_count    <= '0;
      cal_done     <= 1'b0;
      offset_sum   <= '0;
      smoothed     <= '0;
      w_reg        <= cch_pkg::SMOOTHING_WEIGHT_RST;
      g_reg        <= cch_pkg::TURN_GAIN_RST;
      db_reg       <= cch_pkg::DEADBAND_DEGREES_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          cch_pkg::REG_SMOOTHING_WEIGHT: w_reg  <= cfg_data;
          cch_pkg::REG_TURN_GAIN:        g_reg  <= cfg_data;
          cch_pkg::REG_DEADBAND_DEGREES: db_reg <= cfg_data;
          default: begin
          end
        endcase
      end

      if ((state == S_OUT) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            step_idx <= '0;
            state    <= S_ROT;
          end
        end
        S_ROT: begin
          step_idx <= step_idx + 1'b1;
          if (step_idx == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_MLO;
          end
        end
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_HEAD;
        S_HEAD: state <= cal_done ? S_FA : S_CAL;
        S_CAL: begin
          offset_sum <= cal_new;
          cal_count  <= cal_count + 1'b1;
          state      <= (cal_count == CNT_W'(CAL_SAMPLES - 1)) ? S_DIV : S_OUT;
        end
        S_DIV:  state <= S_DIVQ;
        S_DIVQ: begin
          offset_sum <= div_neg ? -div_q : div_q;
          cal_done   <= 1'b1;
          state      <= S_OUT;
        end
        S_FA:   state <= S_FB;
        S_FB:   state <= S_FC;
        S_FC: begin
          smoothed <= filt_new;
          state    <= S_TA;
        end
        S_TA:   state <= S_TB;
        S_TB:   state <= S_OUT;
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_zero;
      zero_r <= (neg_y == '0) && (neg_z == '0);
    end
    case (state)
      S_MHI: acc <= cch_pkg::ACC_W'(prod) + cch_pkg::DEG_ROUND;
      S_FB:  acc <= cch_pkg::ACC_W'(prod) + cch_pkg::ACC_W'(cch_pkg::Q8_HALF);
      default: begin
      end
    endcase
    if (state == S_HEAD) begin
      h_reg  <= zero_r ? '0 : head_calc;
      turn_r <= '0;
    end
    if (state == S_DIV) begin
      div_neg <= offset_sum < 0;
    end
    if (state == S_TB) begin
      turn_r <= turn_val;
    end
    if ((state == S_OUT) && (!result_valid || !result_stall)) begin
      filtered_heading <= smoothed;
      turn_command     <= turn_r;
      calibrated       <= cal_done;
    end
  end

`ifndef SYNTHESIS
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    cal_done |=> cal_done)
    else $error("calibration flag dropped without reset");

  a_cal_turn_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !calibrated |-> turn_command == '0)
    else $error("nonzero turn command before calibration finished");

  a_cal_count_range: assert property (@(posedge clk) disable iff (rst)
    cal_count <= CNT_W'(CAL_SAMPLES))
    else $error("calibration count beyond sample count");

  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_OUT)
    else $error("result presented outside the output step");
`endif

endmodule

@@ tb/compass_heading_hold_tb.sv @@
// Self-checking testbench for the compass heading hold block with its own heading predictor.
`timescale 1ns / 1ps

module compass_heading_hold_tb;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 40;
  localparam int PARK_CYCLES   = 300;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 105;
  localparam int CAL_COUNT     = cch_pkg::CAL_SAMPLES_DEF;
  localparam int ROTATIONS     =
    (cch_pkg::CORDIC_STEPS_DEF < 24) ? cch_pkg::CORDIC_STEPS_DEF : 24;
  localparam logic [cch_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam longint QUARTER_TURN_Q32 = 64'sd6746518852;
  localparam longint DEG_PER_RAD_Q16  = 64'sd3756841;
  localparam longint DEG_ROUND_HALF   = 64'sd549755813888;

  typedef struct packed {
    logic signed [cch_pkg::ANG_W-1:0]  heading;
    logic signed [cch_pkg::TURN_W-1:0] turn;
    logic                              done;
  } compass_out_t;

  typedef struct packed {
    logic signed [cch_pkg::MAG_W-1:0] y;
    logic signed [cch_pkg::MAG_W-1:0] z;
    logic                             hold;
    logic                             typed;
    compass_out_t                     want;
  } probe_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              sample_valid = 1'b0;
  logic                              sample_stall;
  logic signed [cch_pkg::MAG_W-1:0]  mag_y_reading = '0;
  logic signed [cch_pkg::MAG_W-1:0]  mag_z_reading = '0;
  logic                              hold_zero = 1'b0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  logic signed [cch_pkg::ANG_W-1:0]  filtered_heading;
  logic signed [cch_pkg::TURN_W-1:0] turn_command;
  logic                              calibrated;
  logic                              cfg_write = 1'b0;
  logic [cch_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [cch_pkg::CFG_W-1:0]         cfg_data = '0;

  longint arctan_q32_lut [24] = '{
    64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
    64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
    64'sd16777131, 64'sd8388597, 64'sd4194303, 64'sd2097152,
    64'sd1048576, 64'sd524288, 64'sd262144, 64'sd131072,
    64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
    64'sd4096, 64'sd2048, 64'sd1024, 64'sd512
  };

  // Predictor state and its copy of the registers.
  int     cal_count = 0;
  bit     cal_done = 1'b0;
  longint offset_deg = 0;
  longint smooth_q8 = 0;
  int     weight_q8 = int'(cch_pkg::SMOOTHING_WEIGHT_RST);
  int     gain_q8 = int'(cch_pkg::TURN_GAIN_RST);
  int     deadband_deg = int'(cch_pkg::DEADBAND_DEGREES_RST);

  compass_out_t pending[$];
  probe_row_t   probes[$];
  int           errors = 0;
  int           results_seen = 0;
  int           quiet_cycles = 0;
  bit           send_idle = 1'b1;
  bit           recv_idle = 1'b1;
  bit           park_results = 1'b0;

  compass_heading_hold dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .mag_y_reading(mag_y_reading),
    .mag_z_reading(mag_z_reading),
    .hold_zero(hold_zero),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .filtered_heading(filtered_heading),
    .turn_command(turn_command),
    .calibrated(calibrated),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic logic signed [cch_pkg::MAG_W-1:0] negate_axis(
    input logic signed [cch_pkg::MAG_W-1:0] r);
    return -r;
  endfunction

  // Vectoring CORDIC on the negated axes; result is degrees in Q8.
  function automatic longint heading_deg_q8(input logic signed [cch_pkg::MAG_W-1:0] yv,
                                            input logic signed [cch_pkg::MAG_W-1:0] xv);
    longint x, y, ang, dx, dy, t;
    int i;
    x = longint'(xv) * 256;
    y = longint'(yv) * 256;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = QUARTER_TURN_Q32;
      end else begin
        x = -y;
        y = t;
        ang = -QUARTER_TURN_Q32;
      end
    end
    for (i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        ang += arctan_q32_lut[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= arctan_q32_lut[i];
      end
    end
    return (ang * DEG_PER_RAD_Q16 + DEG_ROUND_HALF) >>> 40;
  endfunction

  function automatic compass_out_t step_heading_hold(
    input logic signed [cch_pkg::MAG_W-1:0] ry,
    input logic signed [cch_pkg::MAG_W-1:0] rz,
    input logic hold);
    compass_out_t r;
    longint h, w, g, d, acc, mag, turn, q;
    h = heading_deg_q8(negate_axis(ry), negate_axis(rz));
    turn = 0;
    if (!cal_done) begin
      if (cal_count < CAL_COUNT) begin
        // The running sum keeps whole degrees, truncated toward zero.
        offset_deg = (offset_deg * 256 + h) / 256;
        cal_count++;
      end
      if (cal_count == CAL_COUNT) begin
        q = offset_deg / CAL_COUNT;
        if (offset_deg < 0 && (offset_deg % CAL_COUNT) != 0) q--;
        offset_deg = q;
        cal_count++;
        cal_done = 1'b1;
      end
    end else begin
      w = (weight_q8 > 256) ? 256 : weight_q8;
      g = (gain_q8 > 256) ? 256 : gain_q8;
      d = h - offset_deg * 256;
      acc = (256 - w) * smooth_q8 + w * d + 128;
      smooth_q8 = acc >>> 8;
      mag = (smooth_q8 < 0) ? -smooth_q8 : smooth_q8;
      if (!(hold || (mag >>> 8) < longint'(deadband_deg))) begin
        turn = (g * smooth_q8 + 128) >>> 8;
        if (turn > cch_pkg::TURN_MAX) turn = cch_pkg::TURN_MAX;
        if (turn < cch_pkg::TURN_MIN) turn = cch_pkg::TURN_MIN;
      end
    end
    r.heading = smooth_q8[cch_pkg::ANG_W-1:0];
    r.turn = turn[cch_pkg::TURN_W-1:0];
    r.done = cal_done;
    return r;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int pick_setting();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 256;
      2: return 511;
      default: return int'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic pick_sample(output logic signed [cch_pkg::MAG_W-1:0] y,
                             output logic signed [cch_pkg::MAG_W-1:0] z);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        y = cch_pkg::MAG_W'($urandom);
        z = cch_pkg::MAG_W'($urandom);
      end
      4: begin
        y = cch_pkg::MAG_W'(int'($urandom_range(0, 32)) - 16);
        z = cch_pkg::MAG_W'(int'($urandom_range(0, 32)) - 16);
      end
      5: begin
        y = cch_pkg::MAG_W'(pick_extreme());
        z = cch_pkg::MAG_W'(pick_extreme());
      end
      6: begin
        y = cch_pkg::MAG_W'($urandom);
        z = '0;
        if ($urandom_range(0, 1) == 1) begin
          z = y;
          y = '0;
        end
      end
      default: begin
        y = cch_pkg::MAG_W'(int'($urandom_range(0, 2000)) - 1000);
        z = cch_pkg::MAG_W'(int'($urandom_range(0, 2000)) - 1000);
      end
    endcase
  endtask

  task automatic add_probe(input int y, input int z, input bit hold, input bit typed,
                           input int want_heading, input int want_turn, input bit want_done);
    probe_row_t row;
    row.y = cch_pkg::MAG_W'(y);
    row.z = cch_pkg::MAG_W'(z);
    row.hold = hold;
    row.typed = typed;
    row.want.heading = cch_pkg::ANG_W'(want_heading);
    row.want.turn = cch_pkg::TURN_W'(want_turn);
    row.want.done = want_done;
    probes.push_back(row);
  endtask

  task automatic offer_sample(input logic signed [cch_pkg::MAG_W-1:0] y,
                              input logic signed [cch_pkg::MAG_W-1:0] z,
                              input logic hold, input bit typed, input compass_out_t typed_want);
    int gap;
    compass_out_t want;
    gap = send_idle ? int'($urandom_range(0, 4)) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    mag_y_reading <= y;
    mag_z_reading <= z;
    hold_zero <= hold;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    // The predictor advances on every transaction, typed rows included.
    want = step_heading_hold(y, z, hold);
    pending.push_back(typed ? typed_want : want);
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input int weight, input int gain, input int deadband);
    int k;
    for (k = 0; k < 4; k++) begin
      cfg_write <= 1'b1;
      case (k)
        0: begin
          cfg_index <= REG_SPARE;
          cfg_data <= cch_pkg::CFG_W'($urandom_range(0, 511));
        end
        1: begin
          cfg_index <= cch_pkg::REG_SMOOTHING_WEIGHT;
          cfg_data <= weight[cch_pkg::CFG_W-1:0];
        end
        2: begin
          cfg_index <= cch_pkg::REG_TURN_GAIN;
          cfg_data <= gain[cch_pkg::CFG_W-1:0];
        end
        default: begin
          cfg_index <= cch_pkg::REG_DEADBAND_DEGREES;
          cfg_data <= deadband[cch_pkg::CFG_W-1:0];
        end
      endcase
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    weight_q8 = weight & 511;
    gain_q8 = gain & 511;
    deadband_deg = deadband & 511;
  endtask

  task automatic log_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s at result %0d: got %0d, want %0d", what, results_seen, got, want);
  endtask

  initial begin : stimulus
    logic signed [cch_pkg::MAG_W-1:0] ry, rz;
    int p, n, w, g, db;
    // Calibration rows: every output stays zero until the sixteenth sample sets calibrated.
    add_probe(0, 0, 0, 1, 0, 0, 0);
    add_probe(-32768, -32768, 1, 1, 0, 0, 0);
    add_probe(32767, 32767, 0, 1, 0, 0, 0);
    add_probe(0, -32768, 0, 1, 0, 0, 0);
    add_probe(-32768, 0, 1, 1, 0, 0, 0);
    add_probe(32767, -32768, 0, 1, 0, 0, 0);
    add_probe(-32768, 32767, 0, 1, 0, 0, 0);
    add_probe(-1, -1, 0, 1, 0, 0, 0);
    add_probe(1, 1, 1, 1, 0, 0, 0);
    add_probe(100, 30000, 0, 1, 0, 0, 0);
    add_probe(-100, 30000, 0, 1, 0, 0, 0);
    add_probe(50, 20000, 0, 1, 0, 0, 0);
    add_probe(0, 1, 0, 1, 0, 0, 0);
    add_probe(1, 0, 0, 1, 0, 0, 0);
    add_probe(-1, 0, 1, 1, 0, 0, 0);
    add_probe(0, -1, 0, 1, 0, 0, 1);
    // Tracking rows go through the predictor.
    add_probe(0, 0, 0, 0, 0, 0, 0);
    add_probe(-32768, -32768, 0, 0, 0, 0, 0);
    add_probe(32767, 32767, 0, 0, 0, 0, 0);
    add_probe(0, -32768, 1, 0, 0, 0, 0);
    add_probe(0, 32767, 0, 0, 0, 0, 0);
    add_probe(-32768, 32767, 0, 0, 0, 0, 0);
    add_probe(32767, -32768, 1, 0, 0, 0, 0);
    add_probe(200, -25000, 0, 0, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (probes[i]) begin
      offer_sample(probes[i].y, probes[i].z, probes[i].hold, probes[i].typed, probes[i].want);
    end
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          w = 256;
          g = 256;
          db = 0;
        end
        1: begin
          w = 0;
          g = 0;
          db = 360;
        end
        2: begin
          w = 511;
          g = 511;
          db = 511;
        end
        3: begin
          w = 1;
          g = 255;
          db = 1;
        end
        default: begin
          w = pick_setting();
          g = pick_setting();
          db = ($urandom_range(0, 3) == 0) ? pick_setting() : int'($urandom_range(0, 30));
        end
      endcase
      load_settings(w, g, db);
      send_idle = (p != 2 && p != 6);
      recv_idle = (p != 2 && p != 7);
      // Park the result side for a while so the block backs up into its input.
      if (p == 4) park_results = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick_sample(ry, rz);
        offer_sample(ry, rz, ($urandom_range(0, 3) == 0), 1'b0, '0);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_side
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (park_results) begin
        park_results = 1'b0;
        gap = PARK_CYCLES;
      end else begin
        gap = recv_idle ? int'($urandom_range(0, 4)) : 0;
      end
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  always @(posedge clk) begin : check_results
    compass_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        log_mismatch("transaction with no expectation, heading",
                     longint'(filtered_heading), 0);
      end else begin
        want = pending.pop_front();
        if (filtered_heading !== want.heading)
          log_mismatch("filtered_heading", longint'(filtered_heading),
                       longint'(want.heading));
        if (turn_command !== want.turn)
          log_mismatch("turn_command", longint'(turn_command), longint'(want.turn));
        if (calibrated !== want.done)
          log_mismatch("calibrated", longint'(calibrated), longint'(want.done));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT after %0d cycles with no transaction", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ files.f @@
hw/rtl/cch_pkg.sv
hw/rtl/cch_mul.sv
hw/rtl/cch_cordic.sv
hw/rtl/compass_heading_hold.sv
tb/compass_heading_hold_tb.sv
